[rtl/ptlru_pkg.sv]
// shared types and constants for the page table with lru victim unit
// no dependencies
`timescale 1ns / 1ps
package ptlru_pkg;

  localparam int TABLE_ENTRIES_DEF = 16384;
  localparam int RECENCY_DEPTH_DEF = 256;
  localparam int PAGE_SHIFT_DEF    = 12;
  localparam int FRAME_W           = 8;
  localparam int ENTRY_W           = FRAME_W + 2;
  localparam int VPAGE_W           = 14;
  localparam int CNT_W             = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_MAP    = 2'd1,
    OP_DIRTY  = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MATCH,
    S_COMPACT,
    S_DROP,
    S_APPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic kill_match;
    logic kill_head;
    logic shift;
    logic append;
  } lru_ctrl_t;

endpackage

[rtl/page_table_with_lru_victim_unit.sv]
// top level: page table in ram plus a chain of recency cells
// depends on ptlru_pkg, ptlru_ram, ptlru_cell
`timescale 1ns / 1ps
// usage:
//   raise start with operation, address and frame while busy is low; the item
//   is taken at that edge and busy rises on the next cycle.
//   exactly one result follows: done is high for one cycle with hit,
//   result_frame, victim_found, victim_page, victim_dirty and the three
//   counters; the receiver cannot stall, so the result must be taken then.
//   mark_dirty, missed lookups, ignored maps and empty evicts go from the
//   table read straight to done; evict removes the head, then compacts the
//   chain; a lookup hit or a map removes the page, compacts and appends it,
//   first dropping the oldest and compacting again when the list is full and
//   a new page comes. a gap left by a removed page walks one cell per cycle
//   toward the tail. one item at a time; the next start is taken once busy
//   falls. after reset the page table is cleared one entry per cycle while
//   busy stays high; the recency list comes up empty and the counters at
//   zero.
module page_table_with_lru_victim_unit #(
  parameter int TABLE_ENTRIES = ptlru_pkg::TABLE_ENTRIES_DEF,
  parameter int RECENCY_DEPTH = ptlru_pkg::RECENCY_DEPTH_DEF,
  parameter int PAGE_SHIFT    = ptlru_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [31:0]                    address,
  input  logic [ptlru_pkg::FRAME_W-1:0]  frame,
  output logic                           done,
  output logic                           hit,
  output logic [ptlru_pkg::FRAME_W-1:0]  result_frame,
  output logic                           victim_found,
  output logic [ptlru_pkg::VPAGE_W-1:0]  victim_page,
  output logic                           victim_dirty,
  output logic [ptlru_pkg::CNT_W-1:0]    total_accesses,
  output logic [ptlru_pkg::CNT_W-1:0]    fault_total,
  output logic [ptlru_pkg::CNT_W-1:0]    dirty_evictions
);
  import ptlru_pkg::*;

  localparam int PBITS = $clog2(TABLE_ENTRIES);
  localparam int SBITS = $clog2(RECENCY_DEPTH);

  state_t state, state_next;
  lru_ctrl_t ctrl;

  logic [31:0]        page_full;
  logic               accept;
  logic [PBITS-1:0]   clr;
  logic [SBITS-1:0]   sweep;
  logic               sweep_last;
  logic               clr_last;
  op_t                op_r;
  logic [PBITS-1:0]   key;
  logic               in_range_r;
  logic [FRAME_W-1:0] frame_r;

  logic               ram_we;
  logic [PBITS-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               present;
  logic               is_hit;

  logic [RECENCY_DEPTH-1:0] cell_valid;
  logic [PBITS-1:0]         cell_page [RECENCY_DEPTH];

  logic               hit_r;
  logic [FRAME_W-1:0] rframe_r;
  logic               vfound_r;
  logic [VPAGE_W-1:0] vpage_r;
  logic               vdirty_r;
  logic [CNT_W-1:0]   acc_cnt;
  logic [CNT_W-1:0]   fault_cnt;
  logic [CNT_W-1:0]   devict_cnt;

  assign page_full  = address >> PAGE_SHIFT;
  assign accept     = start && state == S_IDLE;
  assign sweep_last = sweep == SBITS'(RECENCY_DEPTH - 1);
  assign clr_last   = clr == PBITS'(TABLE_ENTRIES - 1);
  assign present    = ram_rdata[FRAME_W];
  assign is_hit     = in_range_r && present;

  ptlru_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  genvar g;
  generate
    for (g = 0; g < RECENCY_DEPTH; g++) begin : g_cell
      logic             pv;
      logic             nv;
      logic [PBITS-1:0] np;
      if (g == 0) begin : g_head
        assign pv = 1'b1;
      end else begin : g_body
        assign pv = cell_valid[g-1];
      end
      if (g == RECENCY_DEPTH - 1) begin : g_tail
        assign nv = 1'b0;
        assign np = '0;
      end else begin : g_mid
        assign nv = cell_valid[g+1];
        assign np = cell_page[g+1];
      end
      ptlru_cell #(.PBITS(PBITS)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .is_head    (g == 0),
        .key        (key),
        .prev_valid (pv),
        .next_valid (nv),
        .next_page  (np),
        .valid      (cell_valid[g]),
        .page       (cell_page[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr_last) state_next = S_IDLE;
      S_IDLE:    if (start) state_next = S_READ;
      S_READ: begin
        case (op_r)
          OP_LOOKUP: state_next = is_hit ? S_MATCH : S_DONE;
          OP_MAP:    state_next = in_range_r ? S_MATCH : S_DONE;
          OP_EVICT:  state_next = cell_valid[0] ? S_COMPACT : S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_MATCH:   state_next = S_COMPACT;
      S_COMPACT: begin
        if (sweep_last) begin
          if (op_r == OP_EVICT) begin
            state_next = S_DONE;
          end else if (cell_valid[RECENCY_DEPTH-1]) begin
            state_next = S_DROP;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_DROP:    state_next = S_COMPACT;
      S_APPEND:  state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ram_we    = 1'b0;
    ram_addr  = key;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr;
      end
      S_IDLE: begin
        ram_addr = (op_t'(operation) == OP_EVICT) ? cell_page[0] : page_full[PBITS-1:0];
      end
      S_READ: begin
        case (op_r)
          OP_MAP: begin
            ram_we    = in_range_r;
            ram_wdata = {ram_rdata[ENTRY_W-1], 1'b1, frame_r};
          end
          OP_DIRTY: begin
            ram_we    = in_range_r;
            ram_wdata = {1'b1, ram_rdata[ENTRY_W-2:0]};
          end
          OP_EVICT: begin
            ram_we         = cell_valid[0];
            ram_wdata      = ram_rdata;
            ram_wdata[FRAME_W] = 1'b0;
            ctrl.kill_head = cell_valid[0];
          end
          default: ram_we = 1'b0;
        endcase
      end
      S_MATCH:   ctrl.kill_match = 1'b1;
      S_COMPACT: ctrl.shift = 1'b1;
      S_DROP:    ctrl.kill_head = 1'b1;
      S_APPEND:  ctrl.append = 1'b1;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      sweep      <= '0;
      acc_cnt    <= '0;
      fault_cnt  <= '0;
      devict_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (state == S_COMPACT && !sweep_last) begin
        sweep <= sweep + 1'b1;
      end else begin
        sweep <= '0;
      end
      if (state == S_READ) begin
        if (op_r == OP_LOOKUP) begin
          acc_cnt <= acc_cnt + 1'b1;
          if (!is_hit) begin
            fault_cnt <= fault_cnt + 1'b1;
          end
        end
        if (op_r == OP_EVICT && cell_valid[0] && ram_rdata[ENTRY_W-1]) begin
          devict_cnt <= devict_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(operation);
      key        <= (op_t'(operation) == OP_EVICT) ? cell_page[0] : page_full[PBITS-1:0];
      in_range_r <= page_full < 32'(TABLE_ENTRIES);
      frame_r    <= frame;
    end
    if (state == S_READ) begin
      hit_r    <= (op_r == OP_LOOKUP) && is_hit;
      rframe_r <= '0;
      vfound_r <= 1'b0;
      vpage_r  <= '0;
      vdirty_r <= 1'b0;
      if (op_r == OP_LOOKUP && is_hit) begin
        rframe_r <= ram_rdata[FRAME_W-1:0];
      end
      if (op_r == OP_EVICT && cell_valid[0]) begin
        rframe_r <= ram_rdata[FRAME_W-1:0];
        vfound_r <= 1'b1;
        vpage_r  <= VPAGE_W'(32'(key));
        vdirty_r <= ram_rdata[ENTRY_W-1];
      end
    end
  end

  assign busy            = state != S_IDLE;
  assign done            = state == S_DONE;
  assign hit             = hit_r;
  assign result_frame    = rframe_r;
  assign victim_found    = vfound_r;
  assign victim_page     = vpage_r;
  assign victim_dirty    = vdirty_r;
  assign total_accesses  = acc_cnt;
  assign fault_total     = fault_cnt;
  assign dirty_evictions = devict_cnt;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |-> !cell_valid[RECENCY_DEPTH-1])
    else $error("append into a full recency list");
  a_drop_frees: assert property (@(posedge clk) disable iff (rst)
    state == S_DROP |=> !cell_valid[0])
    else $error("head not removed on drop");
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted item did not start");

endmodule

[rtl/ptlru_ram.sv]
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ptlru_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/ptlru_cell.sv]
// one slot of the recency chain, slot 0 holds the least recent page
// depends on ptlru_pkg
`timescale 1ns / 1ps
module ptlru_cell #(
  parameter int PBITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  ptlru_pkg::lru_ctrl_t ctrl,
  input  logic                is_head,
  input  logic [PBITS-1:0]    key,
  input  logic                prev_valid,
  input  logic                next_valid,
  input  logic [PBITS-1:0]    next_page,
  output logic                valid,
  output logic [PBITS-1:0]    page
);
  import ptlru_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.kill_match) begin
      if (valid && page == key) begin
        valid <= 1'b0;
      end
    end else if (ctrl.kill_head) begin
      if (is_head) begin
        valid <= 1'b0;
      end
    end else if (ctrl.shift) begin
      // a hole moves one slot toward the tail per cycle
      if (!valid && next_valid) begin
        valid <= 1'b1;
        page  <= next_page;
      end else if (valid && !prev_valid) begin
        valid <= 1'b0;
      end
    end else if (ctrl.append) begin
      if (!valid && prev_valid) begin
        valid <= 1'b1;
        page  <= key;
      end
    end
  end

endmodule
